@@ hdl/lbqm_pkg.sv @@
`default_nettype none
package lbqm_pkg;
  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_APPEND    = 3'd1,
    OP_POP       = 3'd2,
    OP_DELETE    = 3'd3,
    OP_ALLOC     = 3'd4,
    OP_FREE      = 3'd5,
    OP_FLUSH     = 3'd6,
    OP_RELEASE   = 3'd7
  } op_e;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  localparam int unsigned OpW     = 3;
  localparam int unsigned QidW    = 3;
  localparam int unsigned BufW    = 5;
  localparam int unsigned DevW    = 2;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned MaxWalk = 32;

  localparam logic [CfgW-1:0] MaxFreeReset = 6'd8;

  typedef struct packed {
    op_e             op;
    logic [QidW-1:0] qid;
    logic [BufW-1:0] buffer;
    logic [DevW-1:0] device;
  } req_t;
endpackage
`default_nettype wire

@@ hdl/lbqm_req_fifo.sv @@
`default_nettype none
// Two-entry request queue between command front and execution engine.
module lbqm_req_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lbqm_pkg::req_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output lbqm_pkg::req_t     data_o
);
  import lbqm_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

@@ hdl/lbqm_engine.sv @@
`default_nettype none
// Executes one request at a time on the link tables. Walks emit one result per cycle.
module lbqm_engine #(
  parameter int unsigned BUFFERS     = 32,
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned NUM_DEVICES = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  input  wire lbqm_pkg::req_t        req_i,
  output logic                       req_pop_o,
  input  wire logic [lbqm_pkg::CfgW-1:0] max_free_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  output logic [lbqm_pkg::BufW-1:0]  res_handle_o,
  output logic [1:0]                 res_status_o,
  output logic                       res_woke_o,
  output logic                       res_last_o
);
  import lbqm_pkg::*;

  localparam int unsigned LW = $clog2(BUFFERS + 1);
  localparam int unsigned BI = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int unsigned QI = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned DI = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int unsigned TW = $clog2(NUM_QUEUES + NUM_DEVICES + 1);
  localparam int unsigned KW = $clog2(MaxWalk + 1);
  localparam logic [LW-1:0] Nil = LW'(BUFFERS);

  typedef enum logic [1:0] {S_IDLE, S_WALK} state_e;

  logic [LW-1:0] next_q [BUFFERS];
  logic [LW-1:0] prev_q [BUFFERS];
  logic [DI-1:0] owner_q [BUFFERS];
  logic [TW-1:0] tag_q [BUFFERS];
  logic [BUFFERS-1:0] onq_q;
  logic [LW-1:0] qh_q [NUM_QUEUES];
  logic [LW-1:0] qt_q [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] waited_q;
  logic [LW-1:0] ph_q [NUM_DEVICES];
  logic [LW-1:0] pt_q [NUM_DEVICES];
  logic [CfgW-1:0] pc_q [NUM_DEVICES];

  state_e state_q;
  logic [QI-1:0] wq_q;
  logic wrel_q;
  logic [KW-1:0] k_q;

  logic [LW-1:0] next_d [BUFFERS];
  logic [LW-1:0] prev_d [BUFFERS];
  logic [DI-1:0] owner_d [BUFFERS];
  logic [TW-1:0] tag_d [BUFFERS];
  logic [BUFFERS-1:0] onq_d;
  logic [LW-1:0] qh_d [NUM_QUEUES];
  logic [LW-1:0] qt_d [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] waited_d;
  logic [LW-1:0] ph_d [NUM_DEVICES];
  logic [LW-1:0] pt_d [NUM_DEVICES];
  logic [CfgW-1:0] pc_d [NUM_DEVICES];
  state_e state_d;
  logic [QI-1:0] wq_d;
  logic wrel_d;
  logic [KW-1:0] k_d;
  logic rv_d, rw_d, rl_d;
  logic [BufW-1:0] rh_d;
  logic [1:0] rs_d;

  logic q_ok, b_ok, d_ok;
  logic [QI-1:0] qi;
  logic [BI-1:0] bi;
  logic [DI-1:0] di;
  logic [LW-1:0] hb, p, n;
  logic [DI-1:0] fd;
  logic [QI-1:0] cq;
  logic lastw;

  assign q_ok = 32'(req_i.qid) < NUM_QUEUES;
  assign b_ok = 32'(req_i.buffer) < BUFFERS;
  assign d_ok = 32'(req_i.device) < NUM_DEVICES;
  assign qi = QI'(req_i.qid);
  assign bi = BI'(req_i.buffer);
  assign di = DI'(req_i.device);
  assign idle_o = (state_q == S_IDLE) && !req_valid_i;

  always_comb begin
    next_d = next_q; prev_d = prev_q; owner_d = owner_q; tag_d = tag_q;
    onq_d = onq_q; qh_d = qh_q; qt_d = qt_q; waited_d = waited_q;
    ph_d = ph_q; pt_d = pt_q; pc_d = pc_q;
    state_d = state_q; wq_d = wq_q; wrel_d = wrel_q; k_d = k_q;
    rv_d = 1'b0; rh_d = req_i.buffer; rs_d = ST_EMPTY; rw_d = 1'b0; rl_d = 1'b1;
    req_pop_o = 1'b0;
    hb = '0; p = '0; n = '0; fd = '0; lastw = 1'b0;
    cq = (state_q == S_WALK) ? wq_q : qi;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          rv_d = 1'b1;
          case (req_i.op)
            OP_PUSH_HEAD, OP_APPEND: begin
              if (q_ok && b_ok && d_ok && !onq_q[bi]) begin
                if (req_i.op == OP_PUSH_HEAD) begin
                  next_d[bi] = qh_q[qi]; prev_d[bi] = Nil;
                  if (qh_q[qi] != Nil) prev_d[BI'(qh_q[qi])] = LW'(req_i.buffer);
                  else qt_d[qi] = LW'(req_i.buffer);
                  qh_d[qi] = LW'(req_i.buffer);
                end else begin
                  prev_d[bi] = qt_q[qi]; next_d[bi] = Nil;
                  if (qt_q[qi] != Nil) next_d[BI'(qt_q[qi])] = LW'(req_i.buffer);
                  else qh_d[qi] = LW'(req_i.buffer);
                  qt_d[qi] = LW'(req_i.buffer);
                end
                onq_d[bi] = 1'b1;
                tag_d[bi] = TW'(req_i.qid);
                owner_d[bi] = di;
                rw_d = waited_q[qi];
                waited_d[qi] = 1'b0;
                rs_d = ST_DONE;
              end
            end
            OP_POP: begin
              if (q_ok) begin
                if (qh_q[qi] == Nil) begin
                  waited_d[qi] = 1'b1; rh_d = '0;
                end else begin
                  hb = qh_q[qi];
                  n = next_q[BI'(hb)];
                  qh_d[qi] = n;
                  if (n != Nil) prev_d[BI'(n)] = Nil; else qt_d[qi] = Nil;
                  next_d[BI'(hb)] = Nil; prev_d[BI'(hb)] = Nil; onq_d[BI'(hb)] = 1'b0;
                  rh_d = BufW'(hb); rs_d = ST_DONE;
                end
              end
            end
            OP_DELETE: begin
              if (q_ok && b_ok && onq_q[bi] && tag_q[bi] == TW'(req_i.qid)) begin
                p = prev_q[bi]; n = next_q[bi];
                if (p != Nil) next_d[BI'(p)] = n; else qh_d[qi] = n;
                if (n != Nil) prev_d[BI'(n)] = p; else qt_d[qi] = p;
                next_d[bi] = Nil; prev_d[bi] = Nil; onq_d[bi] = 1'b0;
                rs_d = ST_DONE;
              end
            end
            OP_ALLOC: begin
              if (d_ok) begin
                if (ph_q[di] == Nil) begin
                  rh_d = '0;
                end else begin
                  hb = ph_q[di];
                  n = next_q[BI'(hb)];
                  ph_d[di] = n;
                  if (n != Nil) prev_d[BI'(n)] = Nil; else pt_d[di] = Nil;
                  next_d[BI'(hb)] = Nil; prev_d[BI'(hb)] = Nil; onq_d[BI'(hb)] = 1'b0;
                  owner_d[BI'(hb)] = di;
                  if (pc_q[di] != '0) pc_d[di] = pc_q[di] - 1'b1;
                  rh_d = BufW'(hb); rs_d = ST_DONE;
                end
              end
            end
            OP_FREE: begin
              if (b_ok && d_ok && !onq_q[bi]) begin
                owner_d[bi] = di;
                if (pc_q[di] >= max_free_i) begin
                  rs_d = ST_RELEASED;
                end else begin
                  prev_d[bi] = pt_q[di]; next_d[bi] = Nil;
                  if (pt_q[di] != Nil) next_d[BI'(pt_q[di])] = LW'(req_i.buffer);
                  else ph_d[di] = LW'(req_i.buffer);
                  pt_d[di] = LW'(req_i.buffer);
                  onq_d[bi] = 1'b1;
                  tag_d[bi] = TW'(NUM_QUEUES + 32'(di));
                  pc_d[di] = pc_q[di] + 1'b1;
                  rs_d = ST_DONE;
                end
              end
            end
            default: begin
              if (q_ok) begin
                waited_d[qi] = 1'b0;
                if (qh_q[qi] == Nil) begin
                  rh_d = '0;
                end else begin
                  rv_d = 1'b0;
                  state_d = S_WALK; wq_d = qi;
                  wrel_d = (req_i.op == OP_RELEASE); k_d = '0;
                end
              end
            end
          endcase
        end
      end
      default: begin
        // one buffer off the walked queue per cycle
        rv_d = 1'b1;
        hb = qh_q[cq];
        n = next_q[BI'(hb)];
        qh_d[cq] = n;
        if (n != Nil) prev_d[BI'(n)] = Nil; else qt_d[cq] = Nil;
        next_d[BI'(hb)] = Nil; prev_d[BI'(hb)] = Nil; onq_d[BI'(hb)] = 1'b0;
        rh_d = BufW'(hb);
        rs_d = ST_RELEASED;
        if (!wrel_q) begin
          fd = owner_q[BI'(hb)];
          if (32'(fd) >= NUM_DEVICES) fd = '0;
          if (pc_q[fd] < max_free_i) begin
            prev_d[BI'(hb)] = pt_q[fd];
            if (pt_q[fd] != Nil) next_d[BI'(pt_q[fd])] = hb;
            else ph_d[fd] = hb;
            pt_d[fd] = hb;
            onq_d[BI'(hb)] = 1'b1;
            tag_d[BI'(hb)] = TW'(NUM_QUEUES + 32'(fd));
            pc_d[fd] = pc_q[fd] + 1'b1;
            rs_d = ST_DONE;
          end
        end
        lastw = (n == Nil);
        rl_d = lastw;
        k_d = k_q + 1'b1;
        if (lastw || 32'(k_q) == MaxWalk - 1) state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFERS; i++) begin
        next_q[i] <= Nil; prev_q[i] <= Nil; tag_q[i] <= '0;
      end
      onq_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qh_q[i] <= Nil; qt_q[i] <= Nil;
      end
      waited_q <= '0;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        ph_q[i] <= Nil; pt_q[i] <= Nil; pc_q[i] <= '0;
      end
      state_q <= S_IDLE; wq_q <= '0; wrel_q <= 1'b0; k_q <= '0;
      res_valid_o <= 1'b0; res_handle_o <= '0; res_status_o <= '0;
      res_woke_o <= 1'b0; res_last_o <= 1'b0;
    end else begin
      next_q <= next_d; prev_q <= prev_d; tag_q <= tag_d; onq_q <= onq_d;
      qh_q <= qh_d; qt_q <= qt_d; waited_q <= waited_d;
      ph_q <= ph_d; pt_q <= pt_d; pc_q <= pc_d;
      state_q <= state_d; wq_q <= wq_d; wrel_q <= wrel_d; k_q <= k_d;
      res_valid_o <= rv_d; res_handle_o <= rh_d; res_status_o <= rs_d;
      res_woke_o <= rw_d; res_last_o <= rl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= owner_d;
  end
endmodule
`default_nettype wire

@@ hdl/linked_buffer_queue_manager.sv @@
`default_nettype none
// A single-result request is written into the request queue, then the engine takes it
// and its registered result raises strobe (request queue register, engine register).
// Throughput: one request every cycle into a 2-deep queue while busy is low; the engine
// runs one request per cycle when idle, and a flush/release-all walks up to 32 buffers.
// busy is high while the request queue is full. The receiver cannot stall.
// Reset clears all links, queues, pools and counts at once; max_free_bufs resets to 8.
module linked_buffer_queue_manager #(
  parameter int unsigned BUFFERS     = 32,
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned NUM_DEVICES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [2:0]  queue_id_i,
  input  wire logic [4:0]  buffer_i,
  input  wire logic [1:0]  device_i,
  output logic             strobe,
  output logic [4:0]       handle_o,
  output logic [1:0]       status_o,
  output logic             woke_waiter_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lbqm_pkg::*;

  localparam logic [1:0] RegMaxFree = 2'd0;

  req_t in_req, f_req;
  logic full, f_valid, f_pop, idle;
  logic [CfgW-1:0] max_free_q;

  assign in_req = '{op: op_e'(req_type_i), qid: queue_id_i, buffer: buffer_i,
                    device: device_i};
  assign busy = full;
  assign pready = 1'b1;
  assign prdata = (paddr == RegMaxFree) ? {26'd0, max_free_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_free_q <= MaxFreeReset;
    end else if (psel && penable && pwrite && paddr == RegMaxFree) begin
      max_free_q <= pwdata[CfgW-1:0];
    end
  end

  lbqm_req_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(start && !full), .push_data_i(in_req), .full_o(full),
    .pop_i(f_pop), .valid_o(f_valid), .data_o(f_req)
  );

  lbqm_engine #(.BUFFERS(BUFFERS), .NUM_QUEUES(NUM_QUEUES), .NUM_DEVICES(NUM_DEVICES))
  u_engine (
    .clk_i, .rst_ni,
    .req_valid_i(f_valid), .req_i(f_req), .req_pop_o(f_pop),
    .max_free_i(max_free_q), .idle_o(idle),
    .res_valid_o(strobe), .res_handle_o(handle_o), .res_status_o(status_o),
    .res_woke_o(woke_waiter_o), .res_last_o(last_o)
  );

  a_woke_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && woke_waiter_o |-> status_o == ST_DONE && last_o)
    else $error("wake reported on non-insert result");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> status_o != 2'd3)
    else $error("bad status");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle && !start |=> !f_valid)
    else $error("queue holds request while idle");
endmodule
`default_nettype wire
